/* rtl/core/rdc_pkg.sv */
package rdc_pkg;

    localparam int VALUE_W         = 31;
    localparam int BASE_W          = 4;
    localparam int DIGIT_W         = 4;
    localparam int CHUNK_BITS      = 8;
    localparam int DEF_DIGIT_DEPTH = 32;
    localparam int DEF_VALUE_BITS  = 31;

    localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(9);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [BASE_W-1:0]  base;
    } t_req;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               last_digit;
    } t_res;

    typedef struct packed {
        logic load;
        logic step;
        logic fetch;
    } t_cmd;

    typedef struct packed {
        logic div_stop;
        logic last_pop;
    } t_sts;

    function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        r = b;
        if (b < BASE_MIN) r = BASE_MIN;
        if (b > BASE_MAX) r = BASE_MAX;
        return r;
    endfunction

endpackage

/* rtl/core/rdc_ctrl.sv */
module rdc_ctrl
    import rdc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    output logic o_res_valid,
    input  logic i_res_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DIV   = 2'd1;
    localparam logic [1:0] S_FETCH = 2'd2;
    localparam logic [1:0] S_SHOW  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_sts.div_stop) n_state = S_FETCH;
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_SHOW;
            end
            S_SHOW: begin
                o_res_valid = 1'b1;
                if (i_res_ready) n_state = i_sts.last_pop ? S_IDLE : S_FETCH;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule

/* rtl/core/rdc_dpath.sv */
module rdc_dpath
    import rdc_pkg::*;
#(
    parameter int DIGIT_DEPTH = DEF_DIGIT_DEPTH,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_req i_req,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output t_res o_res
);

    localparam int NCHUNK = (VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int WORK_W = NCHUNK * CHUNK_BITS;
    localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int TW     = $clog2(DIGIT_DEPTH + 1);
    localparam int AW     = $clog2(DIGIT_DEPTH);
    localparam int INB    = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;

    logic [DIGIT_W-1:0]  mem [DIGIT_DEPTH];
    logic [WORK_W-1:0]   r_work;
    logic [BASE_W-1:0]   r_base;
    logic [DIGIT_W-1:0]  r_rem;
    logic [CW-1:0]       r_chunk;
    logic [TW-1:0]       r_top;
    logic [DIGIT_W-1:0]  r_rd;
    logic                r_last;

    logic [WORK_W-1:0]     n_work;
    logic [DIGIT_W-1:0]    n_rem;
    logic [CHUNK_BITS-1:0] qbits;
    logic [CHUNK_BITS-1:0] top_bits;
    logic [DIGIT_W:0]      acc;
    logic                  last_chunk;
    logic [TW-1:0]         n_top_pop;

    always_comb begin
        top_bits = r_work[WORK_W-1 -: CHUNK_BITS];
        acc      = {1'b0, r_rem};
        qbits    = '0;
        for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
            acc = {acc[DIGIT_W-1:0], top_bits[i]};
            if (acc >= {1'b0, r_base}) begin
                acc      = acc - {1'b0, r_base};
                qbits[i] = 1'b1;
            end
        end
        n_rem  = acc[DIGIT_W-1:0];
        n_work = WORK_W'({r_work, qbits});
    end

    assign last_chunk = (r_chunk == CW'(NCHUNK - 1));
    assign n_top_pop  = r_top - TW'(1);

    assign o_sts.div_stop = last_chunk && ((n_work == '0) || (r_top == TW'(DIGIT_DEPTH - 1)));
    assign o_sts.last_pop = r_last;
    assign o_res.digit      = r_rd;
    assign o_res.last_digit = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk <= '0;
            r_top   <= '0;
            r_last  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_chunk <= '0;
                r_top   <= '0;
            end else if (i_cmd.step) begin
                if (last_chunk) begin
                    r_chunk <= '0;
                    r_top   <= r_top + TW'(1);
                end else begin
                    r_chunk <= r_chunk + CW'(1);
                end
            end else if (i_cmd.fetch) begin
                r_top  <= n_top_pop;
                r_last <= (n_top_pop == '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_work <= WORK_W'(i_req.value[INB-1:0]);
            r_base <= clamp_base(i_req.base);
            r_rem  <= '0;
        end else if (i_cmd.step) begin
            r_work <= n_work;
            r_rem  <= last_chunk ? '0 : n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && last_chunk) mem[r_top[AW-1:0]] <= n_rem;
        if (i_cmd.fetch)              r_rd <= mem[n_top_pop[AW-1:0]];
    end

endmodule

/* rtl/core/radix_digit_converter.sv */
// Converts an unsigned integer into its digits in a base from 2 to 9.
// Request channel (i_req_valid / o_req_ready / i_req): value and base; a base
// below 2 reads as 2, one above 9 as 9. Only the low VALUE_BITS bits of the
// value are used.
// Result channel (o_res_valid / i_res_ready / o_res): the digits, most
// significant first; last_digit marks the final one. Zero gives the digit 0.
// One request is worked on at a time; o_req_ready is high only while idle.
// Each digit is found by long division in a bit-serial remainder loop of 8 bits
// a cycle, working over the value chunk by chunk, and is pushed onto a digit
// stack memory. Then each digit goes through a registered stack read and a
// result state. A stalled receiver holds the current result and the block.
// Reset returns the block to idle with an empty stack; a result pending at
// reset is dropped.
module radix_digit_converter
    import rdc_pkg::*;
#(
    parameter int DIGIT_DEPTH = DEF_DIGIT_DEPTH,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_res_valid,
    input  logic i_res_ready,
    output t_res o_res
);

    t_cmd cmd;
    t_sts sts;

    rdc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rdc_dpath #(
        .DIGIT_DEPTH (DIGIT_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_res   (o_res)
    );

endmodule
